>>> rtl/owbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and timing constants of the one-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int TIMER_W = 10;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [TIMER_W-1:0] SLOT_TICKS      = TIMER_W'(70);
    localparam logic [TIMER_W-1:0] SHORT_LOW       = TIMER_W'(6);
    localparam logic [TIMER_W-1:0] LONG_LOW        = TIMER_W'(6 + 54);
    localparam logic [TIMER_W-1:0] READ_SAMPLE     = TIMER_W'(6 + 9);
    localparam logic [TIMER_W-1:0] PRESENCE_SAMPLE = TIMER_W'(70);
    localparam logic [TIMER_W-1:0] RESET_REL_TICKS = TIMER_W'(70 + 410);

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_RESET = 2'd1,
        FN_WRITE = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_DONE = 2'd1,
        ST_MODE = 2'd2,
        ST_BUSY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_TICK,
        K_RESET,
        K_WRITE,
        K_READ,
        K_BADMODE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       line_in;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/owbm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_if
// Valid/ready channels of the one-wire bus master: command, result, config.
// ----------------------------------------------------------------------------
interface owbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       line_in;

    modport source (output valid, output func, output data_byte, output line_in,
                    input ready);
    modport sink (input valid, input func, input data_byte, input line_in,
                  output ready);
endinterface

interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic [1:0] status;
    logic       presence;
    logic [7:0] read_data;
    logic       busy_res;

    modport source (output valid, output drive_low, output status, output presence,
                    output read_data, output busy_res, input ready);
    modport sink (input valid, input drive_low, input status, input presence,
                  input read_data, input busy_res, output ready);
endinterface

interface owbm_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// A transaction is written into the command queue when accepted and into the
// result registers when popped. One transaction per clock while results are
// taken; a held result stalls the queue and then the command port. The sequencer
// updates the bus state once per queued transaction. Asynchronous active-low
// reset clears the mode register, queue, sequencer state and result register.
// ----------------------------------------------------------------------------
module one_wire_bus_master
#(
    parameter int RESET_LOW_TICKS = 480
)
(
    input  logic        clk,
    input  logic        rst_n,
    owbm_cfg_if.sink    cfg,
    owbm_cmd_if.sink    cmd,
    owbm_res_if.source  res
);

    owbm_pkg::q_stat_t qstat;
    owbm_pkg::entry_t  push_entry;
    owbm_pkg::entry_t  pop_entry;
    logic              push;
    logic              pop;

    owbm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    owbm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    owbm_back
    #(
        .RESET_LOW_TICKS (RESET_LOW_TICKS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .qstat     (qstat),
        .pop       (pop),
        .res       (res)
    );

endmodule

>>> rtl/owbm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_front
// Holds the line mode register and classifies each accepted command.
// ----------------------------------------------------------------------------
module owbm_front
(
    input  logic               clk,
    input  logic               rst_n,
    owbm_cfg_if.sink           cfg,
    owbm_cmd_if.sink           cmd,
    input  owbm_pkg::q_stat_t  qstat,
    output logic               push,
    output owbm_pkg::entry_t   push_entry
);

    logic open_drain_reg;
    logic open_drain_next;

    assign cfg.ready = 1'b1;
    assign cmd.ready = !qstat.full;
    assign push      = cmd.valid && !qstat.full;

    always_comb
    begin
        open_drain_next = open_drain_reg;
        if (cfg.valid)
        begin
            open_drain_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_drain_reg <= 1'b0;
        end
        else
        begin
            open_drain_reg <= open_drain_next;
        end
    end

    always_comb
    begin
        push_entry.data_byte = cmd.data_byte;
        push_entry.line_in   = cmd.line_in;
        case (owbm_pkg::func_t'(cmd.func))
            owbm_pkg::FN_TICK:  push_entry.kind = owbm_pkg::K_TICK;
            owbm_pkg::FN_RESET: push_entry.kind = open_drain_reg ? owbm_pkg::K_RESET
                                                                 : owbm_pkg::K_BADMODE;
            owbm_pkg::FN_WRITE: push_entry.kind = open_drain_reg ? owbm_pkg::K_WRITE
                                                                 : owbm_pkg::K_BADMODE;
            owbm_pkg::FN_READ:  push_entry.kind = open_drain_reg ? owbm_pkg::K_READ
                                                                 : owbm_pkg::K_BADMODE;
            default:            push_entry.kind = owbm_pkg::K_TICK;
        endcase
    end

endmodule

>>> rtl/owbm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_queue
// Short register queue between the command front and the bus sequencer.
// ----------------------------------------------------------------------------
module owbm_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  owbm_pkg::entry_t   push_entry,
    input  logic               pop,
    output owbm_pkg::entry_t   pop_entry,
    output owbm_pkg::q_stat_t  qstat
);

    owbm_pkg::entry_t                  entry_reg [owbm_pkg::QDEPTH];
    logic [owbm_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [owbm_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [owbm_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [owbm_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [owbm_pkg::QCNT_W-1:0]       count_reg;
    logic [owbm_pkg::QCNT_W-1:0]       count_next;

    assign qstat.full  = (count_reg == owbm_pkg::QCNT_W'(owbm_pkg::QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_entry   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/owbm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_back
// Bus sequencer: runs reset, write and read slots and registers each result.
// ----------------------------------------------------------------------------
module owbm_back
#(
    parameter int RESET_LOW_TICKS = 480
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  owbm_pkg::entry_t   pop_entry,
    input  owbm_pkg::q_stat_t  qstat,
    output logic               pop,
    owbm_res_if.source         res
);

    localparam logic [owbm_pkg::TIMER_W-1:0] RST_LOW_LIM =
        owbm_pkg::TIMER_W'(RESET_LOW_TICKS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_REL,
        PH_WRITE,
        PH_READ
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [owbm_pkg::TIMER_W-1:0]    timer_reg, timer_next, timer_inc;
    logic [2:0]                      bit_reg, bit_next;
    logic [7:0]                      shift_reg, shift_next, shift_rd;
    logic                            presence_reg, presence_next;
    logic [7:0]                      latch_reg, latch_next;
    owbm_pkg::status_t               status_next;
    logic                            drive_next;

    logic                            valid_reg;
    logic                            drive_reg;
    owbm_pkg::status_t               status_reg;

    assign pop = !qstat.empty && (!valid_reg || res.ready);

    assign res.valid     = valid_reg;
    assign res.drive_low = drive_reg;
    assign res.status    = status_reg;
    assign res.presence  = presence_reg;
    assign res.read_data = latch_reg;
    assign res.busy_res  = (phase_reg != PH_IDLE);

    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        latch_next    = latch_reg;
        status_next   = owbm_pkg::ST_NONE;
        timer_inc     = timer_reg + 1'b1;
        shift_rd      = shift_reg;
        if (timer_inc == owbm_pkg::READ_SAMPLE && pop_entry.line_in)
        begin
            shift_rd[bit_reg] = 1'b1;
        end

        case (pop_entry.kind)
            owbm_pkg::K_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    timer_next = timer_inc;
                    case (phase_reg)
                        PH_RST_LOW:
                        begin
                            if (timer_inc >= RST_LOW_LIM)
                            begin
                                phase_next = PH_RST_REL;
                                timer_next = '0;
                            end
                        end
                        PH_RST_REL:
                        begin
                            if (timer_inc == owbm_pkg::PRESENCE_SAMPLE)
                            begin
                                presence_next = !pop_entry.line_in;
                            end
                            if (timer_inc >= owbm_pkg::RESET_REL_TICKS)
                            begin
                                phase_next  = PH_IDLE;
                                timer_next  = '0;
                                status_next = owbm_pkg::ST_DONE;
                            end
                        end
                        PH_WRITE, PH_READ:
                        begin
                            if (phase_reg == PH_READ)
                            begin
                                shift_next = shift_rd;
                            end
                            if (timer_inc >= owbm_pkg::SLOT_TICKS)
                            begin
                                timer_next = '0;
                                if (bit_reg == 3'd7)
                                begin
                                    bit_next    = '0;
                                    phase_next  = PH_IDLE;
                                    status_next = owbm_pkg::ST_DONE;
                                    if (phase_reg == PH_READ)
                                    begin
                                        latch_next = shift_rd;
                                    end
                                end
                                else
                                begin
                                    bit_next = bit_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                        end
                    endcase
                end
            end
            owbm_pkg::K_BADMODE:
            begin
                status_next = owbm_pkg::ST_MODE;
            end
            owbm_pkg::K_RESET, owbm_pkg::K_WRITE, owbm_pkg::K_READ:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    status_next = owbm_pkg::ST_BUSY;
                end
                else
                begin
                    timer_next = '0;
                    bit_next   = '0;
                    if (pop_entry.kind == owbm_pkg::K_RESET)
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    else if (pop_entry.kind == owbm_pkg::K_WRITE)
                    begin
                        phase_next = PH_WRITE;
                        shift_next = pop_entry.data_byte;
                    end
                    else
                    begin
                        phase_next = PH_READ;
                        shift_next = '0;
                    end
                end
            end
            default:
            begin
                status_next = owbm_pkg::ST_NONE;
            end
        endcase

        case (phase_next)
            PH_RST_LOW: drive_next = 1'b1;
            PH_WRITE:   drive_next = timer_next < (shift_next[bit_next] ? owbm_pkg::SHORT_LOW
                                                                        : owbm_pkg::LONG_LOW);
            PH_READ:    drive_next = timer_next < owbm_pkg::SHORT_LOW;
            default:    drive_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            latch_reg    <= '0;
            valid_reg    <= 1'b0;
            drive_reg    <= 1'b0;
            status_reg   <= owbm_pkg::ST_NONE;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                timer_reg    <= timer_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                presence_reg <= presence_next;
                latch_reg    <= latch_next;
                drive_reg    <= drive_next;
                status_reg   <= status_next;
                valid_reg    <= 1'b1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/owbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the result channel of the one-wire bus master.
// ----------------------------------------------------------------------------
module owbm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_drive_low,
    input logic [1:0] res_status,
    input logic       res_busy
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status))
        else $error("Stalled result changed or dropped.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == owbm_pkg::ST_DONE |-> !res_busy)
        else $error("Completed transaction still reports busy.");

    a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == owbm_pkg::ST_BUSY |-> res_busy)
        else $error("Busy rejection while the sequencer is idle.");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_drive_low |-> res_busy)
        else $error("Line driven low while no sequence runs.");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_drive_low (res.drive_low),
    .res_status    (res.status),
    .res_busy      (res.busy_res)
);

>>> tb/tb_one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the one-wire bus master. A queue-fed driver offers
// commands and ticks, and a monitor compares each result transaction with a
// cycle-free model of the reset, write and read slot timing. Traffic covers
// rejected commands in push-pull mode, then a byte write with busy rejects,
// a mode drop while it runs, and a long receiver stall. Both sides insert
// random gaps.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

    localparam int RST_LOW_TICKS = 480;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_REL,
        SEQ_WRITE,
        SEQ_READ
    } seq_t;

    typedef struct packed {
        owbm_pkg::func_t fn;
        logic [7:0]      data;
        logic            line;
    } bus_cmd_t;

    typedef struct packed {
        logic              drive_low;
        owbm_pkg::status_t status;
        logic              presence;
        logic [7:0]        read_data;
        logic              busy;
    } bus_res_t;

    logic clk;
    logic rst_n;

    owbm_cfg_if cfg ();
    owbm_cmd_if cmd ();
    owbm_res_if res ();

    one_wire_bus_master #(
        .RESET_LOW_TICKS(RST_LOW_TICKS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .cmd  (cmd),
        .res  (res)
    );

    // Model state of the bus sequencer.
    logic                         od_mode   = 1'b0;
    seq_t                         seq_state = SEQ_IDLE;
    logic [owbm_pkg::TIMER_W-1:0] slot_tmr  = '0;
    logic [2:0]                   bit_pos   = '0;
    logic [7:0]                   shift_reg = '0;
    logic                         pres_seen = 1'b0;
    logic [7:0]                   rd_latch  = '0;

    bus_cmd_t pend_q[$];
    bus_res_t want_q[$];
    bus_cmd_t tx_item;

    int  tx_wait   = 0;
    int  rx_wait   = 0;
    int  cfg_count = 0;
    int  n_fail    = 0;
    bit  cmd_taken = 1'b0;
    bit  gap_src   = 1'b0;
    bit  gap_snk   = 1'b0;
    bit  rx_hold   = 1'b0;

    function automatic int draw_gap(bit on);
        if (!on || $urandom_range(0, 3) != 0)
        begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic bus_res_t predict_bus(owbm_pkg::func_t fn, logic [7:0] data,
                                             logic line);
        bus_res_t          r;
        owbm_pkg::status_t st;
        logic              bitv;
        st = owbm_pkg::ST_NONE;
        if (fn == owbm_pkg::FN_TICK)
        begin
            if (seq_state != SEQ_IDLE)
            begin
                slot_tmr = slot_tmr + 1'b1;
                case (seq_state)
                    SEQ_RST_LOW:
                    begin
                        if (slot_tmr >= RST_LOW_TICKS)
                        begin
                            seq_state = SEQ_RST_REL;
                            slot_tmr  = '0;
                        end
                    end
                    SEQ_RST_REL:
                    begin
                        if (slot_tmr == owbm_pkg::PRESENCE_SAMPLE)
                        begin
                            pres_seen = !line;
                        end
                        if (slot_tmr >= owbm_pkg::RESET_REL_TICKS)
                        begin
                            seq_state = SEQ_IDLE;
                            slot_tmr  = '0;
                            st        = owbm_pkg::ST_DONE;
                        end
                    end
                    SEQ_READ:
                    begin
                        if (slot_tmr == owbm_pkg::READ_SAMPLE && line)
                        begin
                            shift_reg[bit_pos] = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if ((seq_state == SEQ_WRITE || seq_state == SEQ_READ)
                    && slot_tmr >= owbm_pkg::SLOT_TICKS)
                begin
                    slot_tmr = '0;
                    if (bit_pos == 3'd7)
                    begin
                        bit_pos = '0;
                        if (seq_state == SEQ_READ)
                        begin
                            rd_latch = shift_reg;
                        end
                        seq_state = SEQ_IDLE;
                        st        = owbm_pkg::ST_DONE;
                    end
                    else
                    begin
                        bit_pos = bit_pos + 1'b1;
                    end
                end
            end
        end
        else if (!od_mode)
        begin
            st = owbm_pkg::ST_MODE;
        end
        else if (seq_state != SEQ_IDLE)
        begin
            st = owbm_pkg::ST_BUSY;
        end
        else
        begin
            slot_tmr = '0;
            bit_pos  = '0;
            case (fn)
                owbm_pkg::FN_RESET: seq_state = SEQ_RST_LOW;
                owbm_pkg::FN_WRITE:
                begin
                    seq_state = SEQ_WRITE;
                    shift_reg = data;
                end
                default:
                begin
                    seq_state = SEQ_READ;
                    shift_reg = '0;
                end
            endcase
        end

        bitv        = shift_reg[bit_pos];
        r.drive_low = (seq_state == SEQ_RST_LOW)
                   || (seq_state == SEQ_WRITE
                       && slot_tmr < (bitv ? owbm_pkg::SHORT_LOW : owbm_pkg::LONG_LOW))
                   || (seq_state == SEQ_READ && slot_tmr < owbm_pkg::SHORT_LOW);
        r.status    = st;
        r.presence  = pres_seen;
        r.read_data = rd_latch;
        r.busy      = (seq_state != SEQ_IDLE);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        bus_res_t got;
        bus_res_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                got.drive_low = res.drive_low;
                got.status    = owbm_pkg::status_t'(res.status);
                got.presence  = res.presence;
                got.read_data = res.read_data;
                got.busy      = res.busy_res;
                rx_wait = draw_gap(gap_snk);
                if (want_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result transaction", $realtime);
                    end
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got.drive_low !== want.drive_low || got.status !== want.status
                        || got.presence !== want.presence
                        || got.read_data !== want.read_data || got.busy !== want.busy)
                    begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                        begin
                            $display("%0t: expected low=%b st=%0d pres=%b rd=%02h busy=%b",
                                     $realtime, want.drive_low, want.status,
                                     want.presence, want.read_data, want.busy);
                            $display("%0t:   actual low=%b st=%0d pres=%b rd=%02h busy=%b",
                                     $realtime, got.drive_low, got.status,
                                     got.presence, got.read_data, got.busy);
                        end
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                od_mode = cfg.data;
                cfg_count++;
            end
            cmd_taken = cmd.valid && cmd.ready;
            if (cmd_taken)
            begin
                want_q.push_back(predict_bus(owbm_pkg::func_t'(cmd.func), cmd.data_byte,
                                             cmd.line_in));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(cmd.valid && !cmd_taken))
        begin
            if (tx_wait > 0)
            begin
                cmd.valid <= 1'b0;
                tx_wait--;
            end
            else if (pend_q.size() != 0)
            begin
                tx_item        = pend_q.pop_front();
                cmd.func      <= tx_item.fn;
                cmd.data_byte <= tx_item.data;
                cmd.line_in   <= tx_item.line;
                cmd.valid     <= 1'b1;
                tx_wait        = draw_gap(gap_src);
            end
            else
            begin
                cmd.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
        begin
            res.ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            res.ready <= 1'b0;
            rx_wait--;
        end
        else
        begin
            res.ready <= 1'b1;
        end
    end

    task automatic push_cmd(owbm_pkg::func_t fn, logic [7:0] data, logic line);
        bus_cmd_t c;
        c.fn   = fn;
        c.data = data;
        c.line = line;
        pend_q.push_back(c);
    endtask

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                push_cmd(owbm_pkg::func_t'($urandom_range(1, 3)), 8'($urandom),
                         1'($urandom));
            end
            push_cmd(owbm_pkg::FN_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || cmd.valid || want_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        int seen;
        seen = cfg_count;
        @(negedge clk);
        cfg.data  <= v;
        cfg.valid <= 1'b1;
        wait (cfg_count != seen);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        cmd.valid     = 1'b0;
        cmd.func      = owbm_pkg::FN_TICK;
        cmd.data_byte = '0;
        cmd.line_in   = 1'b1;
        cfg.valid     = 1'b0;
        cfg.data      = 1'b0;
        res.ready     = 1'b0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Push-pull mode rejects every command; an idle tick does nothing.
        push_cmd(owbm_pkg::FN_TICK, 8'h00, 1'b0);
        push_cmd(owbm_pkg::FN_RESET, 8'h00, 1'b1);
        push_cmd(owbm_pkg::FN_WRITE, 8'hFF, 1'b0);
        push_cmd(owbm_pkg::FN_READ, 8'hA5, 1'b1);
        push_cmd(owbm_pkg::FN_TICK, 8'h3C, 1'b1);
        drain();
        write_mode(1'b1);

        gap_src = 1'b1;
        gap_snk = 1'b1;
        push_cmd(owbm_pkg::FN_TICK, 8'h00, 1'b1);
        push_cmd(owbm_pkg::FN_WRITE, 8'($urandom), 1'b1);
        push_ticks(120);
        drain();

        // Mode drops mid-command: the mode check wins over busy, and the
        // running write goes on.
        write_mode(1'b0);
        push_cmd(owbm_pkg::FN_READ, 8'h55, 1'b0);
        push_cmd(owbm_pkg::FN_WRITE, 8'hAA, 1'b1);
        push_cmd(owbm_pkg::FN_TICK, 8'h00, 1'b0);
        drain();
        write_mode(1'b1);

        gap_src = 1'b0;
        gap_snk = 1'b0;
        push_ticks(150);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
        drain();

        gap_src = 1'b1;
        gap_snk = 1'b1;
        push_ticks(150);

        for (int i = 0; i < 20000
             && (pend_q.size() != 0 || cmd.valid || want_q.size() != 0); i++)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        n_fail += want_q.size();
        if (n_fail == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> one_wire_bus_master.f
rtl/owbm_pkg.sv
rtl/owbm_if.sv
rtl/owbm_front.sv
rtl/owbm_queue.sv
rtl/owbm_back.sv
rtl/one_wire_bus_master.sv
rtl/owbm_checker.sv
tb/tb_one_wire_bus_master.sv
